// ----- rtl/elog_pkg.sv -----
package elog_pkg;

  localparam int unsigned TagW   = 16;
  localparam int unsigned LineW  = 16;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned FillW  = 10;
  localparam int unsigned StatW  = 3;

  // tag word: marker flag on top, file tag, message tag
  localparam int unsigned TagWordW = 2 * TagW + 1;
  localparam int unsigned MarkerBit = 2 * TagW;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [StatW-1:0] {
    STS_STORED     = 3'd0,
    STS_NEW_MARKER = 3'd1,
    STS_COUNTED    = 3'd2,
    STS_POP_RECORD = 3'd3,
    STS_POP_MARKER = 3'd4,
    STS_POP_EMPTY  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_DROP_RD
  } state_e;

endpackage

// ----- rtl/elog_ram.sv -----
module elog_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/event_log_fifo_with_drop_count.sv -----
// store push and empty pop: result valid in the cycle after the transfer
// pop of a held entry and push into a nearly full queue: the entry memories are read first,
//   then the result is loaded from their registered read data in the S_POP_RD or S_DROP_RD state
// a new item is taken in the idle state once the previous result is taken or leaves in the same cycle
// reset clears the indexes, state and output valid; the entry memories are not cleared
module event_log_fifo_with_drop_count
  import elog_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [TagW-1:0]          file_tag_i,
  input  logic [LineW-1:0]         line_number_i,
  input  logic [TagW-1:0]          message_tag_i,
  input  logic signed [ValW-1:0]   logged_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [StatW-1:0]         status_o,
  output logic [TagW-1:0]          out_file_tag_o,
  output logic [LineW-1:0]         out_line_number_o,
  output logic [TagW-1:0]          out_message_tag_o,
  output logic signed [ValW-1:0]   out_value_o,
  output logic [CountW-1:0]        drop_count_o,
  output logic [FillW-1:0]         fill_level_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  // wide enough for both the index and the reported fill level
  localparam int unsigned LW = (AW > FillW) ? AW : FillW;

  // entries held, modulo DEPTH
  function automatic logic [AW-1:0] held_f(logic [AW-1:0] w, logic [AW-1:0] r);
    logic [AW-1:0] diff;
    diff = w - r;
    if (w < r) begin
      diff = diff + AW'(DEPTH);
    end
    return diff;
  endfunction

  function automatic logic [AW-1:0] inc_f(logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [FillW-1:0] fill_f(logic [AW-1:0] held);
    logic [LW-1:0] held_w;
    held_w = LW'(held);
    return held_w[FillW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] wi_q, wi_d;
  logic [AW-1:0] ri_q, ri_d;
  logic          out_valid_q, out_valid_d;

  // result payload registers
  logic [StatW-1:0]  res_status_q, res_status_d;
  logic [TagW-1:0]   res_ftag_q, res_ftag_d;
  logic [LineW-1:0]  res_line_q, res_line_d;
  logic [TagW-1:0]   res_mtag_q, res_mtag_d;
  logic [ValW-1:0]   res_val_q, res_val_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;
  logic [FillW-1:0]  res_fill_q, res_fill_d;
  logic              res_load;

  // memory ports, one shared write address and one shared read address
  logic                tag_we, lc_we, val_we, mem_re;
  logic [AW-1:0]       waddr, raddr;
  logic [TagWordW-1:0] tag_wdata, tag_rdata;
  logic [CountW-1:0]   lc_wdata, lc_rdata;
  logic [ValW-1:0]     val_wdata, val_rdata;

  logic          in_xfer;
  logic [AW-1:0] held;
  logic [AW-1:0] prev_wi;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign held       = held_f(wi_q, ri_q);
  assign prev_wi    = (wi_q == '0) ? AW'(DEPTH - 1) : wi_q - AW'(1);

  elog_ram #(.Width(TagWordW), .Depth(DEPTH)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (waddr),
    .wdata_i (tag_wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (tag_rdata)
  );

  elog_ram #(.Width(CountW), .Depth(DEPTH)) u_lc_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (waddr),
    .wdata_i (lc_wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (lc_rdata)
  );

  elog_ram #(.Width(ValW), .Depth(DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (action_i == ACT_PUSH) begin
            if (held >= AW'(DEPTH - 2)) begin
              state_d = S_DROP_RD;
            end
          end else if (held != '0) begin
            state_d = S_POP_RD;
          end
        end
      end
      S_POP_RD:  state_d = S_IDLE;
      S_DROP_RD: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wi_d         = wi_q;
    ri_d         = ri_q;
    tag_we       = 1'b0;
    lc_we        = 1'b0;
    val_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = wi_q;
    raddr        = ri_q;
    tag_wdata    = {1'b0, file_tag_i, message_tag_i};
    lc_wdata     = CountW'(line_number_i);
    val_wdata    = ValW'(logged_value_i);
    res_load     = 1'b0;
    res_status_d = STS_STORED;
    res_ftag_d   = '0;
    res_line_d   = '0;
    res_mtag_d   = '0;
    res_val_d    = '0;
    res_cnt_d    = '0;
    res_fill_d   = fill_f(held);

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (action_i == ACT_PUSH) begin
            if (held < AW'(DEPTH - 2)) begin
              // room left: store the record at the write index
              tag_we       = 1'b1;
              lc_we        = 1'b1;
              val_we       = 1'b1;
              wi_d         = inc_f(wi_q);
              res_load     = 1'b1;
              res_status_d = STS_STORED;
              res_fill_d   = fill_f(held_f(wi_d, ri_q));
            end else begin
              // nearly full: look at the newest entry
              mem_re = 1'b1;
              raddr  = prev_wi;
            end
          end else if (held == '0) begin
            res_load     = 1'b1;
            res_status_d = STS_POP_EMPTY;
            res_fill_d   = '0;
          end else begin
            mem_re = 1'b1;
            raddr  = ri_q;
          end
        end
      end
      S_POP_RD: begin
        ri_d       = inc_f(ri_q);
        res_load   = 1'b1;
        res_fill_d = fill_f(held_f(wi_q, ri_d));
        if (tag_rdata[MarkerBit]) begin
          res_status_d = STS_POP_MARKER;
          res_cnt_d    = lc_rdata;
        end else begin
          res_status_d = STS_POP_RECORD;
          res_ftag_d   = tag_rdata[2*TagW-1:TagW];
          res_mtag_d   = tag_rdata[TagW-1:0];
          res_line_d   = lc_rdata[LineW-1:0];
          res_val_d    = val_rdata;
        end
      end
      S_DROP_RD: begin
        res_load = 1'b1;
        if (tag_rdata[MarkerBit]) begin
          // coalesce into the existing marker, saturating count
          lc_we        = 1'b1;
          waddr        = prev_wi;
          lc_wdata     = (lc_rdata == '1) ? lc_rdata : lc_rdata + CountW'(1);
          res_status_d = STS_COUNTED;
        end else begin
          // append a fresh marker with count one
          tag_we       = 1'b1;
          lc_we        = 1'b1;
          val_we       = 1'b1;
          tag_wdata    = {1'b1, {(2*TagW){1'b0}}};
          lc_wdata     = CountW'(1);
          val_wdata    = '0;
          wi_d         = inc_f(wi_q);
          res_status_d = STS_NEW_MARKER;
          res_fill_d   = fill_f(held_f(wi_d, ri_q));
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wi_q        <= '0;
      ri_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, held until the output transfer
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= res_status_d;
      res_ftag_q   <= res_ftag_d;
      res_line_q   <= res_line_d;
      res_mtag_q   <= res_mtag_d;
      res_val_q    <= res_val_d;
      res_cnt_q    <= res_cnt_d;
      res_fill_q   <= res_fill_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_status_q;
  assign out_file_tag_o    = res_ftag_q;
  assign out_line_number_o = res_line_q;
  assign out_message_tag_o = res_mtag_q;
  assign out_value_o       = $signed(res_val_q);
  assign drop_count_o      = res_cnt_q;
  assign fill_level_o      = res_fill_q;

endmodule
